// ===== sv/six_pulse_scr_firing_sequencer_top_assert.svh =====
// Assertion macros used by the firing sequencer top module.
`ifndef SIX_PULSE_SCR_FIRING_SEQUENCER_TOP_ASSERT_SVH
`define SIX_PULSE_SCR_FIRING_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPSFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPSFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/spsfs_pkg.sv =====
// Types, register indexes and gate table of the six-pulse firing sequencer.
package spsfs_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int INDEX_W     = 5;
    localparam int PHASE_W     = 3;
    localparam int BASE_W      = 16;
    localparam int STEP_W      = 12;
    localparam int PULSE_W     = 16;
    localparam int SPACING_W   = 16;
    localparam int GATE_W      = 6;
    // base + index * step fits in this many bits
    localparam int DELAY_W     = 18;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_DELAY = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_STEP = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_INDEX  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPACING    = 3'd4;

    // Reset values of the configuration registers
    localparam logic [BASE_W-1:0]    BASE_DELAY_RST = 16'd448;
    localparam logic [STEP_W-1:0]    DELAY_STEP_RST = 12'd448;
    localparam logic [INDEX_W-1:0]   MAX_INDEX_RST  = 5'd17;
    localparam logic [PULSE_W-1:0]   PULSE_RST      = 16'd400;
    localparam logic [SPACING_W-1:0] SPACING_RST    = 16'd2776;

    // Phase of the last pair of the sequence
    localparam logic [PHASE_W-1:0]   PHASE_LAST     = 3'd6;

    typedef struct packed {
        logic zero_cross;
        logic step_up;
        logic step_down;
    } in_beat_t;

    typedef struct packed {
        logic [GATE_W-1:0] gate_drive;
        logic              sync_window;
    } out_beat_t;

    // Gate pair driven in each pulse phase
    function automatic logic [GATE_W-1:0] gate_pattern(input logic [PHASE_W-1:0] phase);
        logic [GATE_W-1:0] g;
        case (phase)
            3'd1:    g = 6'h21;
            3'd2:    g = 6'h03;
            3'd3:    g = 6'h06;
            3'd4:    g = 6'h0C;
            3'd5:    g = 6'h18;
            3'd6:    g = 6'h30;
            default: g = 6'h00;
        endcase
        return g;
    endfunction

endpackage

// ===== sv/six_pulse_scr_firing_sequencer_top.sv =====
// Six-pulse thyristor firing sequencer: angle index, delay and pair timers.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid / in_ready  | in_data  (spsfs_pkg::in_beat_t)
//  out     | output    | out_valid/ out_ready | out_data (spsfs_pkg::out_beat_t)
//  cfg     | input     | cfg_we               | cfg_addr, cfg_data
//
// One beat per cycle sustained while out is not stalled; each result is held in the
// output register and appears in the cycle after its input beat is accepted.
// in_ready is high while the output register is empty or is being taken.
// A stall on out holds the result and, once the output register is full,
// holds off the next input beat. Reset clears the sequencer state and out_valid and
// loads the register defaults; there is no clearing pass.
module six_pulse_scr_firing_sequencer_top #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  spsfs_pkg::in_beat_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output spsfs_pkg::out_beat_t                  out_data,
    input  logic                                  cfg_we,
    input  logic [spsfs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [spsfs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    `include "six_pulse_scr_firing_sequencer_top_assert.svh"

    localparam int SUM_W = (TIMER_WIDTH > spsfs_pkg::DELAY_W) ? TIMER_WIDTH
                                                              : spsfs_pkg::DELAY_W;
    localparam logic [SUM_W-1:0] TIMER_TOP = (SUM_W'(1) << TIMER_WIDTH) - SUM_W'(1);

    // Configuration registers
    logic [spsfs_pkg::BASE_W-1:0]    base_delay_reg;
    logic [spsfs_pkg::STEP_W-1:0]    delay_step_reg;
    logic [spsfs_pkg::INDEX_W-1:0]   max_index_reg;
    logic [spsfs_pkg::PULSE_W-1:0]   pulse_reg;
    logic [spsfs_pkg::SPACING_W-1:0] spacing_reg;

    // Sequencer state
    logic [spsfs_pkg::INDEX_W-1:0]   angle_reg,    angle_next;
    logic [spsfs_pkg::PHASE_W-1:0]   phase_reg,    phase_next;
    logic [TIMER_WIDTH-1:0]          interval_reg, interval_next;
    logic [TIMER_WIDTH-1:0]          width_reg,    width_next;
    logic                            waiting_reg,  waiting_next;
    logic                            active_reg,   active_next;

    // Output register
    logic                            out_valid_reg;
    spsfs_pkg::out_beat_t            out_data_reg, out_data_next;

    logic                            accept;
    logic [SUM_W-1:0]                delay_sum;
    logic [TIMER_WIDTH-1:0]          delay_load;
    logic [TIMER_WIDTH-1:0]          pulse_load;
    logic [TIMER_WIDTH-1:0]          spacing_load;
    logic                            fire;
    logic [spsfs_pkg::PHASE_W-1:0]   fire_phase;
    logic [spsfs_pkg::GATE_W-1:0]    gates;

    function automatic logic [TIMER_WIDTH-1:0] sat_timer(input logic [SUM_W-1:0] v);
        logic [TIMER_WIDTH-1:0] r;
        if (v > TIMER_TOP)
        begin
            r = TIMER_TOP[TIMER_WIDTH-1:0];
        end
        else
        begin
            r = v[TIMER_WIDTH-1:0];
        end
        return r;
    endfunction

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_delay_reg <= spsfs_pkg::BASE_DELAY_RST;
            delay_step_reg <= spsfs_pkg::DELAY_STEP_RST;
            max_index_reg  <= spsfs_pkg::MAX_INDEX_RST;
            pulse_reg      <= spsfs_pkg::PULSE_RST;
            spacing_reg    <= spsfs_pkg::SPACING_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                spsfs_pkg::REG_BASE_DELAY: base_delay_reg <= cfg_data;
                spsfs_pkg::REG_DELAY_STEP: delay_step_reg <= cfg_data[spsfs_pkg::STEP_W-1:0];
                spsfs_pkg::REG_MAX_INDEX:  max_index_reg  <= cfg_data[spsfs_pkg::INDEX_W-1:0];
                spsfs_pkg::REG_PULSE:      pulse_reg      <= cfg_data;
                spsfs_pkg::REG_SPACING:    spacing_reg    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Advance the angle index, saturating at both ends
    always_comb
    begin
        angle_next = angle_reg;
        if (in_data.step_up)
        begin
            if (angle_next >= max_index_reg)
            begin
                angle_next = max_index_reg;
            end
            else
            begin
                angle_next = angle_next + spsfs_pkg::INDEX_W'(1);
            end
        end
        if (in_data.step_down && (angle_next != '0))
        begin
            angle_next = angle_next - spsfs_pkg::INDEX_W'(1);
        end
    end

    // Firing delay and saturated timer loads
    assign delay_sum    = SUM_W'(base_delay_reg) + SUM_W'(angle_next) * SUM_W'(delay_step_reg);
    assign delay_load   = sat_timer(delay_sum);
    assign pulse_load   = sat_timer(SUM_W'(pulse_reg));
    assign spacing_load = sat_timer(SUM_W'(spacing_reg));

    // Step the delay, pair and width timers for one tick
    always_comb
    begin
        interval_next = interval_reg;
        width_next    = width_reg;
        phase_next    = phase_reg;
        waiting_next  = waiting_reg;
        active_next   = active_reg;
        fire          = 1'b0;
        fire_phase    = phase_reg + spsfs_pkg::PHASE_W'(1);
        gates         = '0;
        if (in_data.zero_cross)
        begin
            // restart: load delay and drop the gates
            interval_next = delay_load;
            waiting_next  = 1'b1;
            active_next   = 1'b0;
            phase_next    = '0;
            width_next    = '0;
        end
        else
        begin
            if (waiting_reg || active_reg)
            begin
                if (interval_next != '0)
                begin
                    interval_next = interval_next - TIMER_WIDTH'(1);
                end
                if (interval_next == '0)
                begin
                    fire = 1'b1;
                    if (waiting_reg)
                    begin
                        waiting_next = 1'b0;
                        fire_phase   = spsfs_pkg::PHASE_W'(1);
                    end
                end
            end
            if (fire)
            begin
                phase_next = fire_phase;
                width_next = pulse_load;
                if (fire_phase >= spsfs_pkg::PHASE_LAST)
                begin
                    active_next   = 1'b0;
                    interval_next = '0;
                end
                else
                begin
                    active_next   = 1'b1;
                    interval_next = spacing_load;
                end
            end
            if (width_next != '0)
            begin
                gates      = spsfs_pkg::gate_pattern(phase_next);
                width_next = width_next - TIMER_WIDTH'(1);
            end
            if ((width_next == '0) && !active_next && !waiting_next)
            begin
                phase_next = '0;
            end
        end
        out_data_next.gate_drive  = gates;
        out_data_next.sync_window = waiting_next;
    end

    // Update state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg    <= '0;
            phase_reg    <= '0;
            interval_reg <= '0;
            width_reg    <= '0;
            waiting_reg  <= 1'b0;
            active_reg   <= 1'b0;
        end
        else if (accept)
        begin
            angle_reg    <= angle_next;
            phase_reg    <= phase_next;
            interval_reg <= interval_next;
            width_reg    <= width_next;
            waiting_reg  <= waiting_next;
            active_reg   <= active_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks on sequencer state and result beats
    `SPSFS_ASSERT_NEXT(a_zc_opens_window, clk, rst_n, accept && in_data.zero_cross,
        out_valid_reg && out_data_reg.sync_window && (out_data_reg.gate_drive == '0),
        "zero crossing did not open the sync window with gates off")
    `SPSFS_ASSERT_NOW(a_gate_pair, clk, rst_n, out_valid_reg,
        ($countones(out_data_reg.gate_drive) == 0) ||
        ($countones(out_data_reg.gate_drive) == 2),
        "gate drive is not a pair")
    `SPSFS_ASSERT_NOW(a_wait_or_active, clk, rst_n, 1'b1,
        !(waiting_reg && active_reg),
        "delay wait and pair sequence active together")
    `SPSFS_ASSERT_NOW(a_phase_range, clk, rst_n, 1'b1,
        phase_reg <= spsfs_pkg::PHASE_LAST,
        "pulse phase beyond last pair")
    `SPSFS_ASSERT_NEXT(a_window_tracks_wait, clk, rst_n, accept,
        out_data_reg.sync_window == waiting_reg,
        "sync window does not follow delay wait")

endmodule

// ===== verif/six_pulse_scr_firing_sequencer_top_tb.sv =====
// Self-checking testbench of the six-pulse firing sequencer: queued ticks, predictor, scoreboard.
module six_pulse_scr_firing_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMER_W     = 16;
    localparam int HALF_PERIOD = 10;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 300;
    localparam logic [TIMER_W-1:0] TIMER_TOP  = '1;
    localparam logic [spsfs_pkg::PHASE_W-1:0] FIRST_PAIR = 3'd1;

    // Receiver stall patterns, chosen by a slice of the cycle count
    localparam logic [1:0] RX_OPEN   = 2'd0;
    localparam logic [1:0] RX_COIN   = 2'd1;
    localparam logic [1:0] RX_COMB   = 2'd2;
    localparam logic [1:0] RX_SPARSE = 2'd3;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    spsfs_pkg::in_beat_t              in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    spsfs_pkg::out_beat_t             out_data;
    logic                             cfg_we    = 1'b0;
    logic [spsfs_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [spsfs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    six_pulse_scr_firing_sequencer_top #(
        .TIMER_WIDTH(TIMER_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the configuration registers
    logic [spsfs_pkg::BASE_W-1:0]    base_delay   = spsfs_pkg::BASE_DELAY_RST;
    logic [spsfs_pkg::STEP_W-1:0]    delay_step   = spsfs_pkg::DELAY_STEP_RST;
    logic [spsfs_pkg::INDEX_W-1:0]   max_idx      = spsfs_pkg::MAX_INDEX_RST;
    logic [spsfs_pkg::PULSE_W-1:0]   pulse_width  = spsfs_pkg::PULSE_RST;
    logic [spsfs_pkg::SPACING_W-1:0] pair_spacing = spsfs_pkg::SPACING_RST;

    // Predicted sequencer state
    logic [spsfs_pkg::INDEX_W-1:0] angle_idx     = '0;
    logic [spsfs_pkg::PHASE_W-1:0] pair_phase    = '0;
    logic [TIMER_W-1:0]            interval_cnt  = '0;
    logic [TIMER_W-1:0]            width_cnt     = '0;
    logic                          delay_pending = 1'b0;
    logic                          seq_running   = 1'b0;

    spsfs_pkg::in_beat_t  tick_q[$];
    spsfs_pkg::out_beat_t gate_expect_q[$];
    spsfs_pkg::out_beat_t want;
    int unsigned ticks_queued = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;

    int unsigned burst_left  = 1;
    int unsigned gap_left    = 0;
    int unsigned hold_left   = 0;
    logic        hold_done   = 1'b0;
    logic [15:0] rx_cycle    = '0;
    int unsigned idle_cycles = 0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic logic [TIMER_W-1:0] clamp_timer(input logic [31:0] v);
        return (v > 32'(TIMER_TOP)) ? TIMER_TOP : v[TIMER_W-1:0];
    endfunction

    // Fire one gate pair and load the pulse and spacing timers
    function automatic void start_pair(input logic [spsfs_pkg::PHASE_W-1:0] phase);
        pair_phase = phase;
        width_cnt  = clamp_timer(32'(pulse_width));
        if (phase >= spsfs_pkg::PHASE_LAST)
        begin
            seq_running  = 1'b0;
            interval_cnt = '0;
        end
        else
        begin
            seq_running  = 1'b1;
            interval_cnt = clamp_timer(32'(pair_spacing));
        end
    endfunction

    // Advance the predicted sequencer by one tick and return its output beat
    function automatic spsfs_pkg::out_beat_t advance_firing(input spsfs_pkg::in_beat_t beat);
        spsfs_pkg::out_beat_t res;
        logic [31:0]          delay;
        res = '0;
        // Apply up first, then down, each saturating
        if (beat.step_up)
            angle_idx = (angle_idx >= max_idx) ? max_idx : angle_idx + 1'b1;
        if (beat.step_down && angle_idx != '0)
            angle_idx = angle_idx - 1'b1;

        if (beat.zero_cross)
        begin
            // Restart: load the firing delay and drop the gates at once
            delay         = 32'(base_delay) + 32'(angle_idx) * 32'(delay_step);
            interval_cnt  = clamp_timer(delay);
            delay_pending = 1'b1;
            seq_running   = 1'b0;
            pair_phase    = '0;
            width_cnt     = '0;
        end
        else
        begin
            if (delay_pending)
            begin
                if (interval_cnt != '0)
                    interval_cnt = interval_cnt - 1'b1;
                if (interval_cnt == '0)
                begin
                    delay_pending = 1'b0;
                    start_pair(FIRST_PAIR);
                end
            end
            else if (seq_running)
            begin
                if (interval_cnt != '0)
                    interval_cnt = interval_cnt - 1'b1;
                if (interval_cnt == '0)
                    start_pair(pair_phase + 1'b1);
            end
            // Drive the pair of the current phase while its pulse lasts
            if (width_cnt != '0)
            begin
                case (pair_phase)
                    3'd1:    res.gate_drive = 6'b100001;
                    3'd2:    res.gate_drive = 6'b000011;
                    3'd3:    res.gate_drive = 6'b000110;
                    3'd4:    res.gate_drive = 6'b001100;
                    3'd5:    res.gate_drive = 6'b011000;
                    3'd6:    res.gate_drive = 6'b110000;
                    default: res.gate_drive = '0;
                endcase
                width_cnt = width_cnt - 1'b1;
            end
            if (width_cnt == '0 && !seq_running && !delay_pending)
                pair_phase = '0;
        end
        res.sync_window = delay_pending;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input int unsigned got,
                                 input int unsigned exp_val);
        $display("[%0t] mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                 $realtime, field, results_seen, got, exp_val);
        mismatches++;
    endtask

    task automatic queue_tick(input logic zc, input logic up, input logic dn);
        spsfs_pkg::in_beat_t b;
        b.zero_cross = zc;
        b.step_up    = up;
        b.step_down  = dn;
        tick_q.push_back(b);
        ticks_queued++;
    endtask

    // Queue mostly whole firing cycles, some cut short, plus stray crossings
    task automatic queue_random(input int count, input int up_pct, input int down_pct,
                                input int noise_pct);
        int span;
        int until_zc;
        span = int'(base_delay) + int'(max_idx) * int'(delay_step)
             + 5 * int'(pair_spacing) + int'(pulse_width) + 3;
        until_zc = $urandom_range(0, 3);
        for (int i = 0; i < count; i++)
        begin
            queue_tick(until_zc == 0 || $urandom_range(0, 99) < noise_pct,
                       $urandom_range(0, 99) < up_pct,
                       $urandom_range(0, 99) < down_pct);
            until_zc = (until_zc == 0) ? $urandom_range(span / 2, span + 4) : until_zc - 1;
        end
    endtask

    task automatic write_reg(input logic [spsfs_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [spsfs_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
    endtask

    // Wait until every result is in, then write all registers
    task automatic load_config(input logic [spsfs_pkg::BASE_W-1:0]    base,
                               input logic [spsfs_pkg::STEP_W-1:0]    step,
                               input logic [spsfs_pkg::INDEX_W-1:0]   maxi,
                               input logic [spsfs_pkg::PULSE_W-1:0]   pulse,
                               input logic [spsfs_pkg::SPACING_W-1:0] spacing);
        while (results_seen != ticks_queued)
            @(posedge clk);
        write_reg(spsfs_pkg::REG_BASE_DELAY, spsfs_pkg::CFG_DATA_W'(base));
        write_reg(spsfs_pkg::REG_DELAY_STEP, spsfs_pkg::CFG_DATA_W'(step));
        write_reg(spsfs_pkg::REG_MAX_INDEX, spsfs_pkg::CFG_DATA_W'(maxi));
        write_reg(spsfs_pkg::REG_PULSE, spsfs_pkg::CFG_DATA_W'(pulse));
        write_reg(spsfs_pkg::REG_SPACING, spsfs_pkg::CFG_DATA_W'(spacing));
        @(posedge clk);
        cfg_we       <= 1'b0;
        base_delay   = base;
        delay_step   = step;
        max_idx      = maxi;
        pulse_width  = pulse;
        pair_spacing = spacing;
    endtask

    // Driver: offer queued ticks in bursts, predict each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                gate_expect_q.push_back(advance_firing(in_data));
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() != 0)
                begin
                    in_data  <= tick_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (gate_expect_q.size() == 0)
                    note_mismatch("unexpected beat", 32'(out_data), 0);
                else
                begin
                    want = gate_expect_q.pop_front();
                    if (out_data.gate_drive !== want.gate_drive)
                        note_mismatch("gate_drive", 32'(out_data.gate_drive),
                                      32'(want.gate_drive));
                    if (out_data.sync_window !== want.sync_window)
                        note_mismatch("sync_window", 32'(out_data.sync_window),
                                      32'(want.sync_window));
                end
                results_seen++;
            end

            // Hold off once for a long stretch, else follow the stall pattern
            rx_cycle = rx_cycle + 1'b1;
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_cycle[9:8])
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_COMB:   out_ready <= (rx_cycle[2:0] != 3'd0);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("** six_pulse_scr_firing_sequencer_top: FAILED **");
                $finish;
            end
            else
                idle_cycles = idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: one crossing early, the first pair fires late in the run
        queue_random(700, 2, 1, 0);

        // Short timers: saturate the index, step and cross together, restart
        load_config(16'd2, 12'd1, 5'd3, 16'd2, 16'd3);
        repeat (5) queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b1);
        repeat (4) queue_tick(1'b0, 1'b0, 1'b1);
        queue_tick(1'b1, 1'b1, 1'b0);
        repeat (4) queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b0);
        repeat (4) queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b1);
        queue_tick(1'b1, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b1);
        repeat (2) queue_tick(1'b0, 1'b0, 1'b0);
        queue_random(250, 10, 10, 2);

        // All zero: no delay, no pulse width, no spacing, index above the limit
        load_config(16'd0, 12'd0, 5'd0, 16'd0, 16'd0);
        queue_random(120, 15, 15, 5);

        // Pulse wider than spacing, index climbing to the top
        load_config(16'd1, 12'd1, 5'd31, 16'd7, 16'd3);
        queue_random(250, 20, 5, 2);

        // Largest values: the firing delay saturates the timer
        load_config(16'hFFFF, 12'hFFF, 5'd31, 16'hFFFF, 16'hFFFF);
        queue_random(60, 40, 5, 10);

        // Single-tick pulses and spacing, index walking down
        load_config(16'd0, 12'd1, 5'd31, 16'd1, 16'd1);
        queue_random(120, 5, 30, 2);

        // Random short settings
        repeat (4)
        begin
            load_config(16'($urandom_range(0, 15)), 12'($urandom_range(0, 7)),
                        5'($urandom_range(0, 31)), 16'($urandom_range(0, 10)),
                        16'($urandom_range(0, 10)));
            queue_random(50, 10, 10, 3);
        end

        // Drain, then watch for stray beats
        while (results_seen != ticks_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0 && gate_expect_q.size() == 0)
            $display("** six_pulse_scr_firing_sequencer_top: PASSED **");
        else
            $display("** six_pulse_scr_firing_sequencer_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/spsfs_pkg.sv
sv/six_pulse_scr_firing_sequencer_top.sv
verif/six_pulse_scr_firing_sequencer_top_tb.sv
